>>> rtl/sfmf_pkg.sv
// ----------------------------------------------------------------------------
// sfmf_pkg
// Types and constants shared by the split 16.16 matrix to float32 decoder.
// ----------------------------------------------------------------------------
package sfmf_pkg;

  localparam int unsigned CompDefault = 16;
  localparam int unsigned HalfW       = 16;
  localparam int unsigned IdxW        = 4;
  localparam logic [7:0]  ExpBias     = 8'd111;  // 127 - 16: folds in the 2^-16 scale

  typedef struct packed {
    logic [HalfW-1:0] halfword;
    logic             read_fault;
  } in_item_t;

  typedef struct packed {
    logic [31:0]     float_bits;
    logic [IdxW-1:0] component_index;
    logic            last_component;
    logic            fault;
  } out_item_t;

endpackage

>>> rtl/sfmf_ram.sv
// ----------------------------------------------------------------------------
// sfmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfmf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> rtl/split_fixed_matrix_to_float_unit.sv
// ----------------------------------------------------------------------------
// split_fixed_matrix_to_float_unit
// Decodes a matrix sent as split 16.16 halfwords into float32 components.
// ----------------------------------------------------------------------------
// Order: a fraction item is registered in stage 1 (with its store read) at its
//   accepting edge, then converted into the output register when it advances;
//   a fault item too. Integer items give no result.
// Throughput: one item per cycle; input stalls only while stage 1 and the
//   output register both hold an item and the output is stalled.
// Reset: position and valid flags clear; store contents stay undefined.
module split_fixed_matrix_to_float_unit
  import sfmf_pkg::*;
#(
  parameter int unsigned COMPONENTS = CompDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfmf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfmf_pkg::out_item_t out_item_o
);
  localparam int unsigned AW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int unsigned PW = $clog2(2 * COMPONENTS);

  logic in_acc;
  logic adv;

  // Stage 1 -> stage 2 flow: stage 2 (output reg) moves when empty or taken.
  logic             s1_valid_q;   // fraction or fault item waiting for store data
  logic             s1_fault_q;
  logic [HalfW-1:0] s1_frac_q;
  logic [AW-1:0]    s1_comp_q;
  logic             s1_last_q;
  logic [PW-1:0]    pos_q, pos_d;
  logic             out_valid_q;
  out_item_t        out_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  logic in_int;
  logic [AW-1:0] comp_idx;
  assign in_int   = (pos_q < PW'(COMPONENTS));
  assign comp_idx = in_int ? AW'(pos_q) : AW'(pos_q - PW'(COMPONENTS));

  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      if (in_item_i.read_fault || pos_q == PW'(2 * COMPONENTS - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PW'(1);
      end
    end
  end

  // Integer halves are written before any fraction of the same matrix reads
  // them, so write and read never collide on one entry.
  logic [HalfW-1:0] int_rd;
  sfmf_ram #(.Width(HalfW), .Depth(1 << AW)) u_store (
    .clk_i  (clk_i),
    .we_i   (in_acc && in_int && !in_item_i.read_fault),
    .waddr_i(comp_idx),
    .wdata_i(in_item_i.halfword),
    .re_i   (in_acc && !in_int),
    .raddr_i(comp_idx),
    .rdata_o(int_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      // Stage 1 refills when it empties into stage 2 or was empty already.
      if (adv || !s1_valid_q) begin
        s1_valid_q <= in_acc && (in_item_i.read_fault || !in_int);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_fault_q <= in_item_i.read_fault;
      s1_frac_q  <= in_item_i.halfword;
      s1_comp_q  <= comp_idx;
      s1_last_q  <= (pos_q == PW'(2 * COMPONENTS - 1));
    end
  end

  // Conversion: magnitude, leading-one position, shift and RNE round.
  logic [31:0] raw, mag, mant_sh;
  logic        sgn;
  logic [4:0]  p;
  logic [31:0] flt;
  logic [24:0] mant_r;
  logic        guard, sticky;
  logic [7:0]  expo;

  always_comb begin
    raw = {int_rd, s1_frac_q};
    sgn = raw[31];
    mag = sgn ? (32'd0 - raw) : raw;
    p   = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    // Normalize so the leading one sits at bit 31.
    mant_sh = mag << (5'd31 - p);
    guard   = mant_sh[7];
    sticky  = |mant_sh[6:0];
    mant_r  = {1'b0, mant_sh[31:8]};
    if (guard && (sticky || mant_sh[8])) mant_r = mant_r + 25'd1;
    expo = ExpBias + 8'(p);
    if (mant_r[24]) begin
      expo   = expo + 8'd1;
      mant_r = mant_r >> 1;
    end
    flt = (mag == 32'd0) ? 32'd0 : {sgn, expo, mant_r[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_q.fault           <= s1_fault_q;
      out_q.float_bits      <= s1_fault_q ? 32'd0 : flt;
      out_q.component_index <= s1_fault_q ? '0 : IdxW'(s1_comp_q);
      out_q.last_component  <= s1_fault_q ? 1'b0 : s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

>>> rtl/sfmf_checker.sv
// ----------------------------------------------------------------------------
// sfmf_checker
// Port-level checks for the matrix decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfmf_checker
  import sfmf_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sfmf_pkg::out_item_t out_item_o
);
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fault |->
      out_item_o.float_bits == 32'd0 && !out_item_o.last_component)
    else $error("fault item carries data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

  a_fault_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fault |-> out_item_o.component_index == '0)
    else $error("fault item has index");
endmodule

bind split_fixed_matrix_to_float_unit sfmf_checker u_sfmf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the split 16.16 matrix to float32 decoder against its own
// conversion predictor, with random idling on both channels and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import sfmf_pkg::*;

  localparam int unsigned NComp     = CompDefault;
  localparam int unsigned CycleLimit = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  split_fixed_matrix_to_float_unit #(.COMPONENTS(NComp)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predictor state: stored integer halves and position in the matrix
  logic [15:0] int_halves [NComp];
  int unsigned hw_pos;
  out_item_t   pending_comps [$];
  int unsigned n_errors;
  int unsigned cycles;
  bit          idle_on;     // random idling enabled
  bit          hold_off;    // receiver long stall request

  // signed 16.16 raw value to float32 bits, round to nearest even
  function automatic logic [31:0] fixed_to_float(logic [31:0] raw);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    int unsigned p;
    int unsigned s;
    sgn = raw[31];
    mag = sgn ? (32'd0 - raw) : raw;
    if (mag == 0) return 32'd0;
    p = 0;
    for (int i = 31; i >= 0; i--) begin
      if (mag[i]) begin
        p = i;
        break;
      end
    end
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      s = p - 23;
      rem = mag & ((32'd1 << s) - 1);
      half = 32'd1 << (s - 1);
      mant = mag >> s;
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
      if (mant == (32'd1 << 24)) begin
        mant = mant >> 1;
        p = p + 1;
      end
    end
    return {sgn, 8'(p + 111), mant[22:0]};
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_item(in_item_t it);
    out_item_t r;
    int unsigned c;
    if (it.read_fault) begin
      hw_pos = 0;
      r = '0;
      r.fault = 1'b1;
      pending_comps.push_back(r);
    end else if (hw_pos < NComp) begin
      int_halves[hw_pos] = it.halfword;
      hw_pos++;
    end else begin
      c = hw_pos - NComp;
      r.float_bits = fixed_to_float({int_halves[c], it.halfword});
      r.component_index = c[IdxW-1:0];
      r.last_component = (c == NComp - 1);
      r.fault = 1'b0;
      pending_comps.push_back(r);
      hw_pos++;
      if (hw_pos >= 2 * NComp) hw_pos = 0;
    end
  endtask

  // send one item; waits for acceptance, leaves valid high so that the
  // next item can follow in the very next cycle
  task automatic send_item(logic [15:0] hw, logic flt);
    in_item_t it;
    it.halfword = hw;
    it.read_fault = flt;
    while (idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  // receiver stall: random idling, or a long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= idle_on && ($urandom_range(99) < 13);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_comps.size() == 0) begin
        $error("unexpected result %h", out_item);
        n_errors++;
      end else begin
        e = pending_comps.pop_front();
        if (out_item.float_bits !== e.float_bits) begin
          $error("float_bits exp %h got %h", e.float_bits, out_item.float_bits);
          n_errors++;
        end
        if (out_item.component_index !== e.component_index) begin
          $error("component_index exp %0d got %0d", e.component_index,
                 out_item.component_index);
          n_errors++;
        end
        if (out_item.last_component !== e.last_component) begin
          $error("last_component exp %b got %b", e.last_component,
                 out_item.last_component);
          n_errors++;
        end
        if (out_item.fault !== e.fault) begin
          $error("fault exp %b got %b", e.fault, out_item.fault);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // one matrix: integer halves then fractions; abort_at < 2*NComp injects a fault
  task automatic send_matrix(logic [15:0] ints [NComp], logic [15:0] fracs [NComp],
                             int abort_at);
    for (int i = 0; i < 2 * NComp; i++) begin
      if (i == abort_at) begin
        send_item(16'($urandom), 1'b1);
        return;
      end
      send_item(i < NComp ? ints[i] : fracs[i - NComp], 1'b0);
    end
  endtask

  task automatic test_directed();
    logic [15:0] ints [NComp];
    logic [15:0] fracs [NComp];
    // extremes: zero, -1 frac, most negative, most positive, ties for rounding
    logic [31:0] vals [NComp] = '{32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h0100_0001, 32'h0100_0003, 32'h01FF_FFFF, 32'hFFFF_0000,
      32'h0001_0000, 32'h0000_FFFF, 32'hFF00_0001, 32'h0100_0002, 32'h00FF_FFFF,
      32'hFE00_0003, 32'h1234_5678};
    for (int i = 0; i < NComp; i++) begin
      ints[i]  = vals[i][31:16];
      fracs[i] = vals[i][15:0];
    end
    send_matrix(ints, fracs, 2 * NComp);
    send_matrix(ints, fracs, 3);          // fault in the integer half
    send_matrix(ints, fracs, NComp + 5);  // fault in the fraction half
    send_matrix(ints, fracs, 0);          // fault right at the start
  endtask

  task automatic test_random(int n_items);
    logic [15:0] ints [NComp];
    logic [15:0] fracs [NComp];
    int sent;
    int abort_at;
    sent = 0;
    while (sent < n_items) begin
      for (int i = 0; i < NComp; i++) begin
        ints[i]  = 16'($urandom);
        fracs[i] = 16'($urandom);
        if ($urandom_range(7) == 0) ints[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      abort_at = ($urandom_range(9) == 0) ? $urandom_range(2 * NComp - 1) : 2 * NComp;
      send_matrix(ints, fracs, abort_at);
      sent += (abort_at < 2 * NComp) ? abort_at + 1 : 2 * NComp;
      if (sent > n_items / 2 && sent < n_items / 2 + 40) idle_on = 1'b0;  // no-idle stretch
      else idle_on = 1'b1;
    end
  endtask

  // receiver holds off while sender keeps offering
  task automatic test_backpressure();
    logic [15:0] ints [NComp];
    logic [15:0] fracs [NComp];
    for (int i = 0; i < NComp; i++) begin
      ints[i]  = 16'($urandom);
      fracs[i] = 16'($urandom);
    end
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_matrix(ints, fracs, 2 * NComp);
        send_matrix(ints, fracs, 2 * NComp);
        in_valid <= 1'b0;
      end
    join
  endtask

  initial begin
    int unsigned wait_cyc;
    n_errors = 0;
    cycles = 0;
    hw_pos = 0;
    idle_on = 1'b0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    idle_on = 1'b1;
    test_backpressure();
    test_random(1200);
    in_valid <= 1'b0;
    wait_cyc = 0;
    while (pending_comps.size() != 0 && wait_cyc < 20000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (10) @(posedge clk);
    if (n_errors == 0 && pending_comps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
